@@ rtl/vector3_normalize_macros.svh @@
// Assertion macros shared by the vector3_normalize RTL.
// No dependencies.
`ifndef VECTOR3_NORMALIZE_MACROS_SVH
`define VECTOR3_NORMALIZE_MACROS_SVH
`define V3N_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define V3N_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ rtl/v3n_pkg.sv @@
// Shared types for vector3_normalize.
// No dependencies.
package v3n_pkg;
	typedef struct packed {
		logic valid;
		logic adv;
	} v3n_ctl_t;
endpackage

@@ rtl/vector3_normalize.sv @@
// Top level of vector3_normalize: square, root cell chain, divide cell chain.
// Depends on v3n_pkg, v3n_sqrt_cell, v3n_div_cell and the macros header.
//
// channel | valid    | stall    | payload
// in      | valid    | stall    | comp_x comp_y comp_z
// out     | out_valid| out_stall| unit_x unit_y unit_z vec_length zero_vector
//
// One item per cycle while out_stall does not hold the chain; an input register is
// followed by one root-bit cell per root bit and one quotient-bit cell per quotient bit.
// Reset clears all stage valid bits. The whole chain advances unless the last
// result is held by out_stall; holes in the chain are filled while stalled.
`include "vector3_normalize_macros.svh"
module vector3_normalize #(
	parameter int COMP_WIDTH = 16,
	parameter int UNIT_FRAC_BITS = 14
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid,
	output logic                          stall,
	input  logic signed [COMP_WIDTH-1:0]  comp_x,
	input  logic signed [COMP_WIDTH-1:0]  comp_y,
	input  logic signed [COMP_WIDTH-1:0]  comp_z,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [UNIT_FRAC_BITS+1:0] unit_x,
	output logic signed [UNIT_FRAC_BITS+1:0] unit_y,
	output logic signed [UNIT_FRAC_BITS+1:0] unit_z,
	output logic [COMP_WIDTH-1:0]         vec_length,
	output logic                          zero_vector
);
	localparam int CW = COMP_WIDTH;
	localparam int UW = UNIT_FRAC_BITS + 2;
	localparam int SW = 2*CW + 2;
	localparam int NW = CW + UNIT_FRAC_BITS;
	localparam int NS = SW/2;
	localparam int ND = NW;
	localparam int NST = NS + ND + 1;

	logic [NST:0] vld;
	logic [NST:0] adv;
	always_comb begin
		adv[NST] = !vld[NST] || !out_stall;
		for (int i = NST-1; i >= 0; i--) begin
			adv[i] = adv[i+1] || !vld[i+1];
		end
	end
	assign stall = !adv[0];
	assign vld[0] = valid;

	logic [CW-1:0] mx_s1, my_s1, mz_s1;
	logic [2:0]    ng_s1;
	logic [SW-1:0] sum_s1;
	logic          vld_s1;
	logic [CW-1:0] ax, ay, az;
	logic [2*CW-1:0] sqx, sqy, sqz;
	always_comb begin
		ax = comp_x[CW-1] ? CW'(-comp_x) : comp_x;
		ay = comp_y[CW-1] ? CW'(-comp_y) : comp_y;
		az = comp_z[CW-1] ? CW'(-comp_z) : comp_z;
		sqx = ax * ax;
		sqy = ay * ay;
		sqz = az * az;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv[0]) begin
			vld_s1 <= valid;
		end
	end
	assign vld[1] = vld_s1;
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			mx_s1  <= ax;
			my_s1  <= ay;
			mz_s1  <= az;
			ng_s1  <= {comp_z[CW-1], comp_y[CW-1], comp_x[CW-1]};
			sum_s1 <= SW'(sqx) + SW'(sqy) + SW'(sqz);
		end
	end

	logic [SW-1:0]   srem [NS+1];
	logic [SW/2-1:0] sroot [NS+1];
	logic [3*CW-1:0] sside [NS+1];
	assign srem[0]  = sum_s1;
	assign sroot[0] = '0;
	assign sside[0] = {mz_s1, my_s1, mx_s1};
	logic [2:0] sng [NS+1];
	assign sng[0] = ng_s1;
	for (genvar g = 0; g < NS; g++) begin : g_sq
		v3n_pkg::v3n_ctl_t c;
		logic [2:0] ng_q;
		assign c.valid = vld[g+1];
		assign c.adv = adv[g+1];
		v3n_sqrt_cell #(.SW(SW), .CW(CW), .STEP(g)) u_cell (
			.clk, .arst_n, .ctl(c), .rem_i(srem[g]), .root_i(sroot[g]),
			.side_i(sside[g]), .rem_o(srem[g+1]), .root_o(sroot[g+1]),
			.side_o(sside[g+1]), .valid_o(vld[g+2]));
		always_ff @(posedge clk) begin
			if (adv[g+1]) begin
				ng_q <= sng[g];
			end
		end
		assign sng[g+1] = ng_q;
	end

	logic [3*NW-1:0]     dnum [ND+1];
	logic [3*(CW+1)-1:0] drem [ND+1];
	logic [3*NW-1:0]     dquo [ND+1];
	logic [CW-1:0]       dden [ND+1];
	logic [CW+3:0]       dside [ND+1];
	logic [CW-1:0]       len0;
	assign len0 = sroot[NS][CW-1:0];
	assign dden[0] = (len0 == '0) ? CW'(1) : len0;
	assign drem[0] = '0;
	assign dquo[0] = '0;
	assign dnum[0] = {NW'(sside[NS][3*CW-1:2*CW]) << UNIT_FRAC_BITS,
		NW'(sside[NS][2*CW-1:CW]) << UNIT_FRAC_BITS,
		NW'(sside[NS][CW-1:0]) << UNIT_FRAC_BITS};
	assign dside[0] = {len0 == '0, sng[NS], len0};
	for (genvar g = 0; g < ND; g++) begin : g_dv
		v3n_pkg::v3n_ctl_t c;
		assign c.valid = vld[NS+1+g];
		assign c.adv = adv[NS+1+g];
		v3n_div_cell #(.NW(NW), .DW(CW)) u_cell (
			.clk, .arst_n, .ctl(c), .num_i(dnum[g]), .rem_i(drem[g]),
			.quo_i(dquo[g]), .den_i(dden[g]), .side_i(dside[g]),
			.num_o(dnum[g+1]), .rem_o(drem[g+1]), .quo_o(dquo[g+1]),
			.den_o(dden[g+1]), .side_o(dside[g+1]), .valid_o(vld[NS+2+g]));
	end

	logic [UW-1:0] qx, qy, qz;
	logic          zf;
	always_comb begin
		zf = dside[ND][CW+3];
		qx = UW'(dquo[ND][NW-1:0]);
		qy = UW'(dquo[ND][2*NW-1:NW]);
		qz = UW'(dquo[ND][3*NW-1:2*NW]);
		qx = dside[ND][CW] ? UW'(-qx) : qx;
		qy = dside[ND][CW+1] ? UW'(-qy) : qy;
		qz = dside[ND][CW+2] ? UW'(-qz) : qz;
	end
	assign out_valid   = vld[NST];
	assign unit_x      = zf ? '0 : qx;
	assign unit_y      = zf ? '0 : qy;
	assign unit_z      = zf ? '0 : qz;
	assign vec_length  = dside[ND][CW-1:0];
	assign zero_vector = zf;

	`V3N_ASSERT_IMPL(a_zero_len, out_valid && zero_vector, vec_length == '0, "zero flag with length")
	`V3N_ASSERT_IMPL(a_len_zero, out_valid && vec_length == '0, zero_vector, "length zero without flag")
	`V3N_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(vec_length), "held result moved")
	`V3N_ASSERT_IMPL(a_stall, stall, out_valid && out_stall, "input stalled with free output")
endmodule

@@ rtl/v3n_sqrt_cell.sv @@
// One step of the restoring integer square root (one root bit per cell).
// Depends on v3n_pkg.
module v3n_sqrt_cell #(
	parameter int SW = 48,
	parameter int CW = 16,
	parameter int STEP = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  v3n_pkg::v3n_ctl_t    ctl,
	input  logic [SW-1:0]        rem_i,
	input  logic [SW/2-1:0]      root_i,
	input  logic [3*CW-1:0]      side_i,
	output logic [SW-1:0]        rem_o,
	output logic [SW/2-1:0]      root_o,
	output logic [3*CW-1:0]      side_o,
	output logic                 valid_o
);
	localparam int SH = SW - 2 - 2*STEP;
	logic [SW+1:0] trial;
	logic          take;
	logic [SW-1:0] bitv;
	always_comb begin
		bitv  = '0;
		bitv[SH] = 1'b1;
		trial = {2'b00, rem_i} - ({2'b00, (SW)'(root_i) << (SH + 2)} + {2'b00, bitv});
		take  = !trial[SW+1];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (ctl.adv) begin
			valid_o <= ctl.valid;
		end
	end
	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			rem_o  <= take ? trial[SW-1:0] : rem_i;
			root_o <= {root_i[SW/2-2:0], take};
			side_o <= side_i;
		end
	end
endmodule

@@ rtl/v3n_div_cell.sv @@
// One restoring division step for three components sharing one divisor.
// Depends on v3n_pkg.
module v3n_div_cell #(
	parameter int NW = 32,
	parameter int DW = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  v3n_pkg::v3n_ctl_t    ctl,
	input  logic [3*NW-1:0]      num_i,
	input  logic [3*(DW+1)-1:0]  rem_i,
	input  logic [3*NW-1:0]      quo_i,
	input  logic [DW-1:0]        den_i,
	input  logic [DW+3:0]        side_i,
	output logic [3*NW-1:0]      num_o,
	output logic [3*(DW+1)-1:0]  rem_o,
	output logic [3*NW-1:0]      quo_o,
	output logic [DW-1:0]        den_o,
	output logic [DW+3:0]        side_o,
	output logic                 valid_o
);
	logic [3*(DW+1)-1:0] rem_n;
	logic [3*NW-1:0]     num_n, quo_n;
	logic [DW+1:0]       sh, df;
	always_comb begin
		rem_n = '0;
		num_n = '0;
		quo_n = '0;
		sh = '0;
		df = '0;
		for (int i = 0; i < 3; i++) begin
			sh = {rem_i[i*(DW+1) +: DW+1], num_i[i*NW+NW-1]};
			df = sh - {2'b00, den_i};
			num_n[i*NW +: NW] = {num_i[i*NW +: NW-1], 1'b0};
			quo_n[i*NW +: NW] = {quo_i[i*NW +: NW-1], !df[DW+1]};
			rem_n[i*(DW+1) +: DW+1] = df[DW+1] ? sh[DW:0] : df[DW:0];
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (ctl.adv) begin
			valid_o <= ctl.valid;
		end
	end
	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			num_o  <= num_n;
			rem_o  <= rem_n;
			quo_o  <= quo_n;
			den_o  <= den_i;
			side_o <= side_i;
		end
	end
endmodule
